@@ rtl/bcm_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and types of the binary cross morphology core
// no dependencies
package bcm_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int IMG_W_BITS = 11;
	localparam int IMG_H_BITS = 13;
	localparam int OP_BITS    = 2;

	localparam int RST_WIDTH  = 1024;
	localparam int RST_HEIGHT = 1024;

	localparam logic [PIX_W-1:0] PIX_HIGH = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_LOW  = 8'h00;

	localparam logic ACT_PIXEL = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_OPERATION    = 2'd2
	} reg_idx_t;

	typedef enum logic [OP_BITS-1:0] {
		OP_ERODE = 2'd0,
		OP_DILATE = 2'd1,
		OP_OPEN = 2'd2,
		OP_CLOSE = 2'd3
	} op_t;

	typedef struct packed {
		logic emit;
		logic hit;
		logic eol;
		logic eof;
	} pass_res_t;

endpackage

@@ rtl/bcm_in_if.sv @@
`timescale 1ns / 1ps
// input pixel channel: valid/ready handshake with action and pixel payload
// depends on bcm_pkg
interface bcm_in_if;
	import bcm_pkg::*;

	logic             valid;
	logic             ready;
	logic             action;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, output action, output pixel_value, input ready);
	modport sink (input valid, input action, input pixel_value, output ready);
endinterface

@@ rtl/bcm_out_if.sv @@
`timescale 1ns / 1ps
// result pixel channel: valid/ready handshake with pixel and raster markers
// depends on bcm_pkg
interface bcm_out_if;
	import bcm_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] result_pixel;
	logic             end_of_line;
	logic             end_of_frame;

	modport source (output valid, output result_pixel, output end_of_line,
		output end_of_frame, input ready);
	modport sink (input valid, input result_pixel, input end_of_line,
		input end_of_frame, output ready);
endinterface

@@ rtl/bcm_pass.sv @@
`timescale 1ns / 1ps
// one morphology pass: ring line store in a synchronous memory, emit control,
// cross window evaluation in the cycle after the step; depends on bcm_pkg
module bcm_pass #(
	parameter int MAX_WIDTH  = bcm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bcm_pkg::DEF_MAX_HEIGHT,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                has_pixel,
	input  logic                pix_bit,
	input  logic [WW-1:0]       width,
	input  logic [HW-1:0]       height,
	output bcm_pkg::pass_res_t  res
);
	import bcm_pkg::*;

	localparam int RING = 2 * MAX_WIDTH + 2;
	localparam int AW   = $clog2(RING);
	localparam int PW   = $clog2(RING + 1);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);

	// word a holds bits a-2, a-1, a
	logic [2:0] mem [RING];

	logic [AW-1:0] wr_q;
	logic [AW-1:0] old_q;
	logic [PW-1:0] pend_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [1:0]    hist_q;

	logic          saturated;
	logic [AW-1:0] wr_next;
	logic [PW-1:0] pend_next;
	logic [AW-1:0] old_base;
	logic [AW-1:0] addr_r;
	logic [AW-1:0] addr_u;
	logic          last_col;
	logic          last_row;
	logic [PW-1:0] need;
	logic          emit;
	logic          one_left;
	logic          two_left;
	logic [1:0]    newest;
	logic [2:0]    fwd;
	logic          use_fwd;

	logic          emit_s1;
	logic          use_fwd_s1;
	logic [2:0]    fwd_s1;
	logic          down_s1;
	logic          left_en_s1;
	logic          right_en_s1;
	logic          up_en_s1;
	logic          down_en_s1;
	logic          eol_s1;
	logic          eof_s1;
	logic [2:0]    rd_r_s1;
	logic          rd_u_s1;
	logic [2:0]    win;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
		return (a == AW'(RING - 1)) ? '0 : a + AW'(1);
	endfunction

	always_comb begin
		saturated = (pend_q == PW'(RING));
		wr_next   = has_pixel ? ring_inc(wr_q) : wr_q;
		pend_next = (has_pixel && !saturated) ? pend_q + PW'(1) : pend_q;
		old_base  = (has_pixel && saturated) ? ring_inc(old_q) : old_q;
		addr_r    = ring_inc(old_base);
		if (old_base >= AW'(width)) begin
			addr_u = old_base - AW'(width);
		end else begin
			addr_u = old_base - AW'(width) + AW'(RING);
		end
		last_col = (WW'(col_q) + WW'(1)) >= width;
		last_row = (HW'(row_q) + HW'(1)) >= height;
		need     = !last_row ? PW'(width) : PW'(!last_col);
		emit     = pend_next > need;
		one_left = (pend_next == PW'(1));
		two_left = (pend_next == PW'(2));
		newest   = has_pixel ? {hist_q[0], pix_bit} : hist_q;
		fwd      = one_left ? {newest, 1'b0} : {hist_q, pix_bit};
		use_fwd  = one_left || (two_left && has_pixel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			old_q   <= '0;
			pend_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			hist_q  <= '0;
			emit_s1 <= 1'b0;
		end else if (step) begin
			emit_s1 <= emit;
			wr_q    <= wr_next;
			if (has_pixel) begin
				hist_q <= newest;
			end
			if (emit) begin
				pend_q <= pend_next - PW'(1);
				old_q  <= addr_r;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else begin
				pend_q <= pend_next;
				old_q  <= old_base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			use_fwd_s1  <= use_fwd;
			fwd_s1      <= fwd;
			down_s1     <= newest[0];
			left_en_s1  <= (col_q != '0);
			right_en_s1 <= !last_col;
			up_en_s1    <= (row_q != '0);
			down_en_s1  <= !last_row;
			eol_s1      <= last_col;
			eof_s1      <= last_col && last_row;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_pixel) begin
			mem[wr_q] <= {hist_q, pix_bit};
		end
		if (step && emit) begin
			rd_r_s1 <= mem[addr_r];
			rd_u_s1 <= mem[addr_u][0];
		end
	end

	always_comb begin
		win      = use_fwd_s1 ? fwd_s1 : rd_r_s1;
		res.emit = emit_s1;
		res.hit  = win[1] | (left_en_s1 & win[2]) | (right_en_s1 & win[0]) |
			(up_en_s1 & rd_u_s1) | (down_en_s1 & down_s1);
		res.eol  = eol_s1;
		res.eof  = eof_s1;
	end

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(RING))
		else $error("pending count beyond ring size");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= AW'(RING - 1) && old_q <= AW'(RING - 1))
		else $error("ring pointer out of range");

	a_ptr_relation: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(wr_q) - int'(pend_q) == int'(old_q)) ||
		(int'(wr_q) - int'(pend_q) + RING == int'(old_q)))
		else $error("oldest pointer out of step with write pointer and count");

endmodule

@@ rtl/binary_cross_morphology_core.sv @@
`timescale 1ns / 1ps
// binary 4-neighbour cross morphology core: two cascaded passes over ring line stores, the
// second used only for open and close; depends on bcm_pkg, bcm_in_if, bcm_out_if, bcm_pass
//
//   channel     | dir | handshake     | payload
//   in_stream   | in  | valid / ready | action, pixel_value
//   out_stream  | out | valid / ready | result_pixel, end_of_line, end_of_frame
//   wr_*        | in  | wr_en         | wr_index, wr_data
//
// one transaction per clock unless the output stalls; a result passes the memory read
// register of pass one, that of pass two or the bypass register, and the output register
// a result trails its pixel by at most one row per pass; drain items flush the tail
// reset clears pointers, counters and pipeline valids; line stores are not cleared
// a stalled output holds the stage registers and lowers in_stream.ready
module binary_cross_morphology_core #(
	parameter int MAX_WIDTH  = bcm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bcm_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [bcm_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [bcm_pkg::CFG_DATA_W-1:0]   wr_data,
	bcm_in_if.sink                           in_stream,
	bcm_out_if.source                        out_stream
);
	import bcm_pkg::*;

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
	localparam int H_RST = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

	logic [WW-1:0]    width_q;
	logic [HW-1:0]    height_q;
	op_t              op_q;

	logic             two_pass;
	logic [PIX_W-1:0] spread1;
	logic [PIX_W-1:0] spread_out;
	logic             fire_in;
	logic             adv1;
	logic             adv2;
	logic             valid_s1;
	logic             valid_s2;
	pass_res_t        byp_s2;
	pass_res_t        p1_res;
	pass_res_t        p2_res;
	pass_res_t        r2;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_eol_q;
	logic             out_eof_q;

	function automatic logic [WW-1:0] clamp_width(input logic [IMG_W_BITS-1:0] v);
		int t;
		t = int'(v);
		if (t < 1) t = 1;
		if (t > MAX_WIDTH) t = MAX_WIDTH;
		return WW'(t);
	endfunction

	function automatic logic [HW-1:0] clamp_height(input logic [IMG_H_BITS-1:0] v);
		int t;
		t = int'(v);
		if (t < 1) t = 1;
		if (t > MAX_HEIGHT) t = MAX_HEIGHT;
		return HW'(t);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RST);
			height_q <= HW'(H_RST);
			op_q     <= OP_ERODE;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH: begin
					width_q <= clamp_width(wr_data[IMG_W_BITS-1:0]);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= clamp_height(wr_data[IMG_H_BITS-1:0]);
				end
				REG_OPERATION: begin
					op_q <= op_t'(wr_data[OP_BITS-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	assign two_pass   = (op_q == OP_OPEN) || (op_q == OP_CLOSE);
	assign spread1    = ((op_q == OP_ERODE) || (op_q == OP_OPEN)) ? PIX_HIGH : PIX_LOW;
	assign spread_out = two_pass ? ~spread1 : spread1;

	// pipeline flow
	assign r2     = two_pass ? p2_res : byp_s2;
	assign adv2   = valid_s2 && (!r2.emit || !out_valid_q || out_stream.ready);
	assign adv1   = valid_s1 && (!valid_s2 || adv2);
	assign in_stream.ready = !valid_s1 || adv1;
	assign fire_in = in_stream.valid && in_stream.ready;

	bcm_pass #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pass1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (fire_in),
		.has_pixel (in_stream.action == ACT_PIXEL),
		.pix_bit   (in_stream.pixel_value == spread1),
		.width     (width_q),
		.height    (height_q),
		.res       (p1_res)
	);

	// second pass sees a match where the first pass did not spread
	bcm_pass #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pass2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv1 && two_pass),
		.has_pixel (p1_res.emit),
		.pix_bit   (!p1_res.hit),
		.width     (width_q),
		.height    (height_q),
		.res       (p2_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_in) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2 && r2.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			byp_s2 <= p1_res;
		end
		if (adv2 && r2.emit) begin
			out_pix_q <= r2.hit ? spread_out : ~spread_out;
			out_eol_q <= r2.eol;
			out_eof_q <= r2.eof;
		end
	end

	assign out_stream.valid        = out_valid_q;
	assign out_stream.result_pixel = out_pix_q;
	assign out_stream.end_of_line  = out_eol_q;
	assign out_stream.end_of_frame = out_eof_q;

	a_binary_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pix_q == PIX_HIGH || out_pix_q == PIX_LOW))
		else $error("result pixel not binary");

	a_eof_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_eof_q) |-> out_eol_q)
		else $error("end of frame without end of line");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stream.ready |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free stage");

	a_stage2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv2) |=> valid_s2)
		else $error("stage two transaction lost while stalled");

endmodule

@@ dv/binary_cross_morphology_checker.sv @@
`timescale 1ns / 1ps
// result checker for the binary cross morphology core: follows register writes and input
// transactions, predicts each result pixel and compares it in order with the output channel
// depends on bcm_pkg, bcm_in_if, bcm_out_if
module binary_cross_morphology_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bcm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bcm_pkg::CFG_DATA_W-1:0] wr_data,
	bcm_in_if                              in_stream,
	bcm_out_if                             out_stream,
	output int                             mismatches,
	output int                             pending,
	output int                             results_checked
);
	import bcm_pkg::*;

	localparam int LINE_SLOTS   = 2 * DEF_MAX_WIDTH + 2;
	localparam int FIRST_PASS   = 0;
	localparam int SECOND_PASS  = 1;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             eol;
		logic             eof;
	} result_pix_t;

	bit          match_line [2][LINE_SLOTS];
	int unsigned line_wr [2];
	int unsigned line_pend [2];
	int unsigned out_col [2];
	int unsigned out_row [2];

	logic [IMG_W_BITS-1:0] cfg_width;
	logic [IMG_H_BITS-1:0] cfg_height;
	op_t                   cfg_op;

	result_pix_t expected_pixels [$];
	result_pix_t want;
	result_pix_t got;
	int          mismatch_count;
	int          checked_count;

	function automatic bit cross_pass_step(input int p, input bit has_pix, input bit mbit,
			input int unsigned w, input int unsigned h, output bit hit, output bit eol,
			output bit eof);
		int unsigned need, o, col, row;
		bit m;
		hit = 1'b0;
		eol = 1'b0;
		eof = 1'b0;
		if (has_pix) begin
			match_line[p][line_wr[p]] = mbit;
			line_wr[p] = (line_wr[p] + 1) % LINE_SLOTS;
			if (line_pend[p] < LINE_SLOTS)
				line_pend[p]++;
		end
		if (line_pend[p] == 0)
			return 1'b0;
		col = out_col[p];
		row = out_row[p];
		if (row + 1 < h)
			need = w;
		else
			need = (col + 1 < w) ? 1 : 0;
		if (line_pend[p] <= need)
			return 1'b0;
		o = (line_wr[p] + LINE_SLOTS - line_pend[p]) % LINE_SLOTS;
		m = match_line[p][o];
		if (col > 0)
			m |= match_line[p][(o + LINE_SLOTS - 1) % LINE_SLOTS];
		if (col + 1 < w)
			m |= match_line[p][(o + 1) % LINE_SLOTS];
		if (row > 0)
			m |= match_line[p][(o + LINE_SLOTS - w) % LINE_SLOTS];
		if (row + 1 < h)
			m |= match_line[p][(o + w) % LINE_SLOTS];
		hit = m;
		eol = (col + 1 >= w);
		eof = eol && (row + 1 >= h);
		if (eol) begin
			out_col[p] = 0;
			out_row[p] = eof ? 0 : row + 1;
		end else begin
			out_col[p] = col + 1;
		end
		line_pend[p]--;
		return 1'b1;
	endfunction

	function automatic void predict_transaction(input logic act, input logic [PIX_W-1:0] pix);
		int unsigned w, h;
		logic [PIX_W-1:0] spread, spread2, value;
		bit hit, eol, eof, emit, two_pass;
		result_pix_t r;
		w = (cfg_width == 0) ? 1 : cfg_width;
		if (w > DEF_MAX_WIDTH)
			w = DEF_MAX_WIDTH;
		h = (cfg_height == 0) ? 1 : cfg_height;
		if (h > DEF_MAX_HEIGHT)
			h = DEF_MAX_HEIGHT;
		two_pass = (cfg_op == OP_OPEN || cfg_op == OP_CLOSE);
		spread = (cfg_op == OP_ERODE || cfg_op == OP_OPEN) ? PIX_HIGH : PIX_LOW;
		spread2 = ~spread;
		value = PIX_LOW;
		emit = cross_pass_step(FIRST_PASS, act == ACT_PIXEL, pix == spread, w, h, hit, eol, eof);
		if (emit)
			value = hit ? spread : ~spread;
		if (two_pass) begin
			if (emit)
				emit = cross_pass_step(SECOND_PASS, 1'b1, value == spread2, w, h, hit, eol, eof);
			else
				emit = cross_pass_step(SECOND_PASS, 1'b0, 1'b0, w, h, hit, eol, eof);
			if (emit)
				value = hit ? spread2 : ~spread2;
		end
		if (emit) begin
			r.pixel = value;
			r.eol = eol;
			r.eof = eof;
			expected_pixels.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 2; p++) begin
				line_wr[p] = 0;
				line_pend[p] = 0;
				out_col[p] = 0;
				out_row[p] = 0;
			end
			cfg_width = IMG_W_BITS'(RST_WIDTH);
			cfg_height = IMG_H_BITS'(RST_HEIGHT);
			cfg_op = OP_ERODE;
			expected_pixels.delete();
			mismatch_count = 0;
			checked_count = 0;
			mismatches <= 0;
			pending <= 0;
			results_checked <= 0;
		end else begin
			if (out_stream.valid && out_stream.ready) begin
				got.pixel = out_stream.result_pixel;
				got.eol = out_stream.end_of_line;
				got.eof = out_stream.end_of_frame;
				if (expected_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result: pixel %0d eol %b eof %b",
							got.pixel, got.eol, got.eof);
				end else begin
					want = expected_pixels.pop_front();
					checked_count++;
					if (got.pixel !== want.pixel || got.eol !== want.eol || got.eof !== want.eof) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("result %0d: expected pixel %0d eol %b eof %b, got pixel %0d eol %b eof %b",
								checked_count, want.pixel, want.eol, want.eof,
								got.pixel, got.eol, got.eof);
					end
				end
			end
			// a transaction on the same edge as a register write still sees the old value
			if (in_stream.valid && in_stream.ready)
				predict_transaction(in_stream.action, in_stream.pixel_value);
			if (wr_en) begin
				case (wr_index)
					REG_IMAGE_WIDTH:  cfg_width = wr_data[IMG_W_BITS-1:0];
					REG_IMAGE_HEIGHT: cfg_height = wr_data[IMG_H_BITS-1:0];
					REG_OPERATION:    cfg_op = op_t'(wr_data[OP_BITS-1:0]);
					default: ;
				endcase
			end
			mismatches <= mismatch_count;
			results_checked <= checked_count;
			pending <= expected_pixels.size();
		end
	end

endmodule

@@ dv/binary_cross_morphology_core_tb.sv @@
`timescale 1ns / 1ps
// top of the binary cross morphology core testbench: clock, reset, frame stimulus with
// random idling on both channels, and the verdict from the result checker
// depends on bcm_pkg, bcm_in_if, bcm_out_if, binary_cross_morphology_core, the checker
module binary_cross_morphology_core_tb;
	import bcm_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TARGET_ITEMS  = 550;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic                 ACT_DRAIN = ~ACT_PIXEL;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	bcm_in_if  in_stream ();
	bcm_out_if out_stream ();

	int          mismatches;
	int          pending;
	int          results_checked;
	int          idle_pct = 0;
	int          stall_left = 0;
	int          cycle_count = 0;
	int          pixels_sent = 0;
	int          drains_sent = 0;
	int          frames_sent = 0;
	int unsigned cur_width;
	int unsigned cur_height;

	int unsigned           k;
	int unsigned           frames;
	logic [CFG_DATA_W-1:0] width_data;
	logic [CFG_DATA_W-1:0] height_data;
	logic [PIX_W-1:0]      probe_pixels [6] = '{PIX_LOW, PIX_HIGH, 8'd254, PIX_HIGH, 8'd1, 8'h80};

	binary_cross_morphology_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_stream  (in_stream),
		.out_stream (out_stream)
	);

	binary_cross_morphology_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.in_stream       (in_stream),
		.out_stream      (out_stream),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// output back-pressure in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stream.ready <= 1'b0;
		end else if (stall_left != 0) begin
			out_stream.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			out_stream.ready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stream.ready <= 1'b1;
		end
	end

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w_data,
			input logic [CFG_DATA_W-1:0] h_data, input op_t op);
		logic [CFG_DATA_W-1:0] op_data;
		op_data = CFG_DATA_W'($urandom());
		op_data[OP_BITS-1:0] = op;
		write_reg(REG_IMAGE_WIDTH, w_data);
		write_reg(REG_IMAGE_HEIGHT, h_data);
		write_reg(REG_OPERATION, op_data);
		wr_en <= 1'b0;
		cur_width = clamp_dim(w_data[IMG_W_BITS-1:0], DEF_MAX_WIDTH);
		cur_height = clamp_dim(h_data, DEF_MAX_HEIGHT);
	endtask

	// drop valid and wait until every predicted result has left the core
	task automatic wait_quiet();
		in_stream.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input logic act, input logic [PIX_W-1:0] pix);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_stream.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_stream.valid <= 1'b1;
		in_stream.action <= act;
		in_stream.pixel_value <= pix;
		@(posedge clk);
		while (!in_stream.ready)
			@(posedge clk);
		if (act == ACT_PIXEL)
			pixels_sent++;
		else
			drains_sent++;
	endtask

	task automatic flush_frame();
		repeat (2 * cur_width + 4) send_item(ACT_DRAIN, PIX_W'($urandom()));
		frames_sent++;
	endtask

	task automatic send_frame(input int unsigned grey_pct, input int unsigned drain_pct,
			input bit hold_midway);
		int unsigned high_pct, total, i;
		logic [PIX_W-1:0] pix;
		high_pct = $urandom_range(15, 85);
		total = cur_width * cur_height;
		for (i = 0; i < total; i++) begin
			if ($urandom_range(99) < drain_pct)
				send_item(ACT_DRAIN, PIX_W'($urandom()));
			if (hold_midway && i == total / 2)
				wait_quiet();
			if ($urandom_range(99) < grey_pct)
				pix = PIX_W'($urandom());
			else
				pix = ($urandom_range(99) < high_pct) ? PIX_HIGH : PIX_LOW;
			send_item(ACT_PIXEL, pix);
		end
		flush_frame();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_stream.valid = 1'b0;
		in_stream.action = ACT_PIXEL;
		in_stream.pixel_value = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset operation, width written with spare upper bits set
		idle_pct = 20;
		write_reg(REG_IMAGE_WIDTH, 13'h1801);
		write_reg(REG_IMAGE_HEIGHT, 13'd10);
		wr_en <= 1'b0;
		cur_width = 1;
		cur_height = 10;
		send_frame(10, 0, 1'b0);

		// small fixed frames, one per operation, then single pixel frames
		wait_quiet();
		idle_pct = 0;
		for (k = 0; k < 4; k++) begin
			wait_quiet();
			configure(13'd3, 13'd2, op_t'(k));
			foreach (probe_pixels[j])
				send_item(ACT_PIXEL, probe_pixels[j]);
			flush_frame();
		end
		wait_quiet();
		configure(13'd0, 13'd0, OP_DILATE);
		send_item(ACT_PIXEL, PIX_HIGH);
		flush_frame();
		send_item(ACT_PIXEL, PIX_LOW);
		flush_frame();

		// masked geometry writes, then a stall in the middle of a frame
		wait_quiet();
		idle_pct = 10;
		write_reg(REG_SPARE, 13'h1FFF);
		configure(13'h1805, 13'd3, OP_OPEN);
		send_frame(10, 8, 1'b0);
		wait_quiet();
		idle_pct = 30;
		configure(13'd8, 13'd6, OP_OPEN);
		send_frame(10, 8, 1'b1);

		// random geometry and operation, mostly small frames
		while (pixels_sent + drains_sent < TARGET_ITEMS) begin
			wait_quiet();
			if (pixels_sent + drains_sent > TARGET_ITEMS * 4 / 5) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
			end
			width_data = CFG_DATA_W'($urandom());
			width_data[IMG_W_BITS-1:0] = ($urandom_range(4) == 0)
				? IMG_W_BITS'($urandom_range(9, 16)) : IMG_W_BITS'($urandom_range(1, 8));
			height_data = ($urandom_range(4) == 0) ? CFG_DATA_W'($urandom_range(7, 10))
				: CFG_DATA_W'($urandom_range(1, 6));
			configure(width_data, height_data, op_t'($urandom_range(3)));
			frames = $urandom_range(1, 2);
			repeat (frames) begin
				send_frame(10, 8, 1'b0);
			end
		end
		wait_quiet();

		if (pending != 0)
			$display("%0d predicted results never arrived", pending);
		$display("%0d pixel and %0d drain transactions in %0d frames, %0d results compared",
			pixels_sent, drains_sent, frames_sent, results_checked);
		$display("all four operations on frames from 1x1 to 16 wide, grey pixels, masked writes");
		if (mismatches == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bcm_pkg.sv
rtl/bcm_in_if.sv
rtl/bcm_out_if.sv
rtl/bcm_pass.sv
rtl/binary_cross_morphology_core.sv
dv/binary_cross_morphology_checker.sv
dv/binary_cross_morphology_core_tb.sv
